FILE: hw/rtl/sliding_window_median_filter_assert.svh
// assertion macros for the median filter
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define SWMF_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// next-cycle implication checked outside reset
`define SWMF_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

FILE: hw/rtl/swmf_pkg.sv
// ---------------------------------------------------------------------------
// swmf_pkg
// shared types and constants of the sliding window median filter
// ---------------------------------------------------------------------------
`default_nettype none
package swmf_pkg;
   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_RADIUS = 2;
   localparam int DEF_PIXEL_BITS = 16;
   localparam int CSR_DATA_BITS  = 12;
   localparam int CSR_IDX_BITS   = 1;
   localparam int COL_BITS       = 11;
   localparam int ROW_BITS       = 12;
   localparam int WIDTH_BITS     = 12;
   localparam int RADIUS_BITS    = 2;
   localparam int OUT_PIXEL_BITS = 16;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_FRAME_WIDTH = 1'b0,
      CSR_RADIUS      = 1'b1
   } csr_index_type;
endpackage
`default_nettype wire

FILE: hw/rtl/swmf_stream_if.sv
// ---------------------------------------------------------------------------
// swmf_stream_if
// valid/ready channel carrying a packed payload
// ---------------------------------------------------------------------------
`default_nettype none
interface swmf_stream_if #(
   parameter int DATA_BITS = 17
);
   logic                 valid;
   logic                 ready;
   logic [DATA_BITS-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/swmf_ram.sv
// ---------------------------------------------------------------------------
// swmf_ram
// single-port-write, single-port-read ram with registered read data
// ---------------------------------------------------------------------------
`default_nettype none
module swmf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

FILE: hw/rtl/swmf_median.sv
// ---------------------------------------------------------------------------
// swmf_median
// pipelined rank-select median over a square window
// ---------------------------------------------------------------------------
`default_nettype none
module swmf_median #(
   parameter int MAX_RADIUS = 2,
   parameter int PIXEL_BITS = 16,
   parameter int TAG_BITS   = 23
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            in_valid,
   input  wire logic [TAG_BITS-1:0]             in_tag,
   input  wire logic [$clog2(MAX_RADIUS+1)-1:0] in_radius,
   input  wire logic [PIXEL_BITS-1:0]           in_win [(2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)],
   input  wire logic                            stall,
   output logic                                 out_valid,
   output logic      [TAG_BITS-1:0]             out_tag,
   output logic      [PIXEL_BITS-1:0]           out_median
);
   localparam int SIDE = 2*MAX_RADIUS + 1;
   localparam int N    = SIDE*SIDE;
   localparam int CB   = $clog2(N+1);

   // stage 1: pairwise compares of the active samples, registered
   logic [PIXEL_BITS-1:0] win_ff [N];
   logic [N-1:0]          act_ff;
   logic [CB-1:0]         rank_ff;
   logic [N-1:0]          lt_ff [N];
   logic [N-1:0]          eq_ff [N];
   logic                  v1_ff;
   logic [TAG_BITS-1:0]   tag1_ff;
   logic [N-1:0]          act_in;
   logic [N-1:0]          lt_in [N];
   logic [N-1:0]          eq_in [N];
   logic [CB-1:0]         rank_in;

   always_comb begin
      for (int j = 0; j < SIDE; j++) begin
         for (int i = 0; i < SIDE; i++) begin
            act_in[j*SIDE+i] = (j < 2*int'(in_radius)+1) && (i < 2*int'(in_radius)+1);
         end
      end
      for (int a = 0; a < N; a++) begin
         for (int b = 0; b < N; b++) begin
            lt_in[a][b] = act_in[b] && (in_win[b] < in_win[a]);
            eq_in[a][b] = act_in[b] && (in_win[b] == in_win[a]) && (b < a);
         end
      end
      rank_in = CB'(((2*int'(in_radius)+1)*(2*int'(in_radius)+1))/2);
   end

   // stage 2: count, select
   logic [N-1:0]          hit_ff;
   logic [PIXEL_BITS-1:0] win2_ff [N];
   logic                  v2_ff;
   logic [TAG_BITS-1:0]   tag2_ff;
   logic [N-1:0]          hit_in;

   always_comb begin
      for (int a = 0; a < N; a++) begin
         logic [CB-1:0] lo;
         logic [CB-1:0] eqc;
         lo  = CB'($countones(lt_ff[a]));
         eqc = CB'($countones(eq_ff[a]));
         // sample a is the chosen one when lo + earlier-equal == rank
         hit_in[a] = act_ff[a] && (CB'(lo + eqc) == rank_ff);
      end
   end

   always_comb begin
      out_median = '0;
      for (int a = 0; a < N; a++) begin
         out_median = out_median | (win2_ff[a] & {PIXEL_BITS{hit_ff[a]}});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (!stall) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (!stall) begin
         win_ff  <= in_win;
         act_ff  <= act_in;
         lt_ff   <= lt_in;
         eq_ff   <= eq_in;
         rank_ff <= rank_in;
         tag1_ff <= in_tag;
         hit_ff  <= hit_in;
         win2_ff <= win_ff;
         tag2_ff <= tag1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_tag   = tag2_ff;
endmodule
`default_nettype wire

FILE: hw/rtl/sliding_window_median_filter.sv
// ---------------------------------------------------------------------------
// sliding_window_median_filter
// streaming square median filter over raster-order pixels
// ---------------------------------------------------------------------------
// usage:
//  - req channel carries {start_of_frame, pixel}; one pixel per transfer in
//    raster order, start_of_frame on the first pixel of a frame
//  - rsp channel carries {out_row, out_column, median}; one transfer for each
//    pixel that completes a full (2r+1)x(2r+1) window, border pixels are
//    never sent
//  - csr port writes frame_width (index 0) and radius (index 1); write only
//    while the block is idle
//  - throughput: one pixel per cycle while rsp does not stall; set by the
//    single line-store ram read/write per pixel
//  - path from req transfer to rsp valid: ram read, window update, compare,
//    select, output register; the ram read starts at the transfer edge
//  - line stores live in one ram of 2*MAX_RADIUS rows x MAX_WIDTH words,
//    read and rewritten as one wide word per column
//  - when rsp stalls the whole pipe holds and req ready drops in the same
//    cycle, until the waiting result is taken
//  - reset clears the position counters and the pipe; the rams hold junk
//    until written and need no clearing pass
// ---------------------------------------------------------------------------
`default_nettype none
`include "sliding_window_median_filter_assert.svh"
module sliding_window_median_filter #(
   parameter int MAX_WIDTH  = swmf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_RADIUS = swmf_pkg::DEF_MAX_RADIUS,
   parameter int PIXEL_BITS = swmf_pkg::DEF_PIXEL_BITS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   swmf_stream_if.sink                               req,
   swmf_stream_if.source                             rsp,
   input  wire logic                                 csr_wr_en,
   input  wire logic [swmf_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [swmf_pkg::CSR_DATA_BITS-1:0]   csr_wr_data
);
   localparam int SIDE    = 2*MAX_RADIUS + 1;
   localparam int N       = SIDE*SIDE;
   localparam int NLINES  = 2*MAX_RADIUS;
   localparam int AB      = $clog2(MAX_WIDTH);
   localparam int RB      = $clog2(MAX_RADIUS+1);
   localparam int CB      = swmf_pkg::COL_BITS;
   localparam int ROWB    = swmf_pkg::ROW_BITS;
   localparam int TAGB    = CB + ROWB;
   localparam int WMAX    = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
   localparam int LW      = NLINES*PIXEL_BITS;

   // configuration registers
   logic [swmf_pkg::WIDTH_BITS-1:0]  width_ff;
   logic [swmf_pkg::RADIUS_BITS-1:0] radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 12'd2048;
         radius_ff <= 2'd1;
      end else if (csr_wr_en) begin
         unique case (swmf_pkg::csr_index_type'(csr_index))
            swmf_pkg::CSR_FRAME_WIDTH: width_ff  <= csr_wr_data;
            swmf_pkg::CSR_RADIUS:      radius_ff <= csr_wr_data[swmf_pkg::RADIUS_BITS-1:0];
            default: ;
         endcase
      end
   end

   // effective width and radius after saturation
   logic [swmf_pkg::WIDTH_BITS:0] wid_eff;
   logic [RB-1:0]                 rad_eff;
   always_comb begin
      if (width_ff == '0) begin
         wid_eff = 13'd1;
      end else if (int'(width_ff) > WMAX) begin
         wid_eff = 13'(WMAX);
      end else begin
         wid_eff = {1'b0, width_ff};
      end
      if (int'(radius_ff) > MAX_RADIUS) begin
         rad_eff = RB'(MAX_RADIUS);
      end else begin
         rad_eff = RB'(radius_ff);
      end
   end

   // pipeline control: stall everything while a result waits unaccepted
   logic stall;
   logic rsp_valid_ff;
   assign stall     = rsp_valid_ff && !rsp.ready;
   assign req.ready = !stall;

   logic                  in_xfer;
   logic [PIXEL_BITS-1:0] in_pixel;
   logic                  in_sof;
   assign in_xfer  = req.valid && req.ready;
   assign in_pixel = req.data[PIXEL_BITS-1:0];
   assign in_sof   = req.data[PIXEL_BITS];

   // position counters
   logic [CB-1:0]   col_ff, col_in, col_cur;
   logic [ROWB-1:0] row_ff, row_in, row_cur;
   always_comb begin
      col_cur = in_sof ? '0 : col_ff;
      row_cur = in_sof ? '0 : row_ff;
      if ({2'b0, col_cur} + 13'd1 >= wid_eff) begin
         col_in = '0;
         row_in = (row_cur < {ROWB{1'b1}}) ? ROWB'(row_cur + 1'b1) : row_cur;
      end else begin
         col_in = CB'(col_cur + 1'b1);
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (in_xfer) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   logic [AB-1:0] addr_cur;
   assign addr_cur = (int'(col_cur) < MAX_WIDTH) ? AB'(col_cur) : AB'(MAX_WIDTH-1);

   // stage a: ram read issued; pixel and position carried along
   logic                  va_ff;
   logic [PIXEL_BITS-1:0] pix_a_ff;
   logic [AB-1:0]         addr_a_ff;
   logic [CB-1:0]         col_a_ff;
   logic [ROWB-1:0]       row_a_ff;

   // line store ram: one wide word holds all row slots of one column
   logic [LW-1:0] ram_rd;
   logic [LW-1:0] line_wr;
   logic          ram_we;
   swmf_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_lines (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(addr_a_ff),
      .wr_data(line_wr),
      .rd_en  (in_xfer),
      .rd_addr(addr_cur),
      .rd_data(ram_rd)
   );

   // forwarding: the word being written this cycle may be the one read
   logic [LW-1:0] fwd_ff;
   logic          fwd_hit_ff;
   logic [LW-1:0] line_old;
   assign line_old = fwd_hit_ff ? fwd_ff : ram_rd;
   assign ram_we   = va_ff && !stall;
   assign line_wr  = {line_old[LW-PIXEL_BITS-1:0], pix_a_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff      <= 1'b0;
         fwd_hit_ff <= 1'b0;
      end else if (!stall) begin
         va_ff      <= in_xfer;
         fwd_hit_ff <= in_xfer && va_ff && (addr_cur == addr_a_ff);
      end
      if (!stall) begin
         fwd_ff    <= line_wr;
         pix_a_ff  <= in_pixel;
         addr_a_ff <= addr_cur;
         col_a_ff  <= col_cur;
         row_a_ff  <= row_cur;
      end
   end

   // stage b: window shift, column vector built from line store slots
   logic [PIXEL_BITS-1:0] win_ff [N];
   logic [PIXEL_BITS-1:0] colv [SIDE];
   always_comb begin
      for (int i = 0; i < SIDE; i++) begin
         colv[i] = '0;
         if (i == 2*int'(rad_eff)) begin
            colv[i] = pix_a_ff;
         end else if (i < 2*int'(rad_eff)) begin
            // slot k = 2r-1-i
            for (int k = 0; k < NLINES; k++) begin
               if (k == 2*int'(rad_eff)-1-i) begin
                  colv[i] = line_old[k*PIXEL_BITS +: PIXEL_BITS];
               end
            end
         end
      end
   end

   logic            vb_ff;
   logic [TAGB-1:0] tag_b_ff;
   logic            emit_a;
   assign emit_a = ({1'b0, row_a_ff} >= ROWB'(2*int'(rad_eff)) + 13'd0)
                   && ({2'b0, col_a_ff} >= 13'(2*int'(rad_eff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (!stall) begin
         vb_ff <= va_ff && emit_a;
      end
      if (!stall && va_ff) begin
         for (int j = SIDE-1; j > 0; j--) begin
            for (int i = 0; i < SIDE; i++) begin
               win_ff[j*SIDE+i] <= win_ff[(j-1)*SIDE+i];
            end
         end
         for (int i = 0; i < SIDE; i++) begin
            win_ff[i] <= colv[i];
         end
      end
      if (!stall) begin
         tag_b_ff <= {ROWB'(row_a_ff - ROWB'(rad_eff)), CB'(col_a_ff - CB'(rad_eff))};
      end
   end

   // stages c and d: median select
   logic                  med_valid;
   logic [TAGB-1:0]       med_tag;
   logic [PIXEL_BITS-1:0] med_val;
   swmf_median #(
      .MAX_RADIUS(MAX_RADIUS),
      .PIXEL_BITS(PIXEL_BITS),
      .TAG_BITS  (TAGB)
   ) u_median (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vb_ff),
      .in_tag    (tag_b_ff),
      .in_radius (rad_eff),
      .in_win    (win_ff),
      .stall     (stall),
      .out_valid (med_valid),
      .out_tag   (med_tag),
      .out_median(med_val)
   );

   // output register
   logic [TAGB+swmf_pkg::OUT_PIXEL_BITS-1:0] rsp_data_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!stall) begin
         rsp_valid_ff <= med_valid;
      end
      if (!stall) begin
         rsp_data_ff <= {med_tag, swmf_pkg::OUT_PIXEL_BITS'(med_val)};
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

   `SWMF_ASSERT_IMP(a_hold_ready, clock, reset, stall, !req.ready)
   `SWMF_ASSERT_NEXT(a_rsp_holds, clock, reset, stall, rsp.valid && $stable(rsp.data))
   `SWMF_ASSERT_IMP(a_fwd_only_valid, clock, reset, fwd_hit_ff, va_ff)
endmodule
`default_nettype wire
